// File: design/lru_slot_weight_allocator_defines.svh
// assertion macros for the slot allocator
`ifndef LRU_SLOT_WEIGHT_ALLOCATOR_DEFINES_SVH
`define LRU_SLOT_WEIGHT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSWA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define LSWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: design/lswa_pkg.sv
`default_nettype none

package lswa_pkg;

  localparam int MAX_SLOTS   = 8;
  localparam int NUM_TARGETS = 256;

  localparam int IDX_W    = 8;
  localparam int SLOT_W   = 3;
  localparam int CNT_W    = 4;
  localparam int WEIGHT_W = 17;
  localparam int RAW_W    = 19;
  localparam int TCNT_W   = 9;
  localparam int STATUS_W = 2;
  localparam int REG_W    = 2;

  localparam logic [WEIGHT_W-1:0] W_ONE = 17'h10000;

  localparam logic [CNT_W-1:0]  SLOTS_FULL    = CNT_W'(MAX_SLOTS);
  localparam logic [TCNT_W-1:0] TARGETS_LIMIT = TCNT_W'(NUM_TARGETS);

  localparam logic [STATUS_W-1:0] ST_UPDATE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SMALL  = 2'd3;

  localparam logic [REG_W-1:0] REG_TARGET_COUNT     = 2'd0;
  localparam logic [REG_W-1:0] REG_CHANGE_THRESHOLD = 2'd1;

  localparam logic [TCNT_W-1:0]   TARGET_COUNT_RST     = 9'd256;
  localparam logic [WEIGHT_W-1:0] CHANGE_THRESHOLD_RST = 17'd66;

  // result tdata layout
  localparam int OUT_SLOT_LSB     = 0;
  localparam int OUT_WEIGHT_LSB   = 3;
  localparam int OUT_EV_VALID_BIT = 20;
  localparam int OUT_EV_INDEX_LSB = 21;

  typedef struct packed {
    logic [IDX_W-1:0]  target;
    logic [SLOT_W-1:0] slot;
  } ord_entry_t;

endpackage

`default_nettype wire

// File: design/lru_slot_weight_allocator.sv
// result path: an out-of-range index goes from acceptance straight to the output state,
//   a change that is too small passes the scan first, otherwise the scan (at least one
//   entry), a prep state and the shift of recency entries down come before the output state
// transactions: one at a time, taken only while idle; the scan and shift walk the
//   recency memory one entry per cycle (eviction at full occupancy is slowest)
// reset: occupancy and weight valid bits cleared, registers to 256 and 66, outputs idle
`default_nettype none

module lru_slot_weight_allocator
  import lswa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [31:0]         s_tdata,   // target_index, new_weight
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [31:0]              m_tdata,   // slot, applied_weight, evicted_valid,
                                              // evicted_index
  output logic [STATUS_W-1:0]      m_tuser,   // status
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [REG_W-1:0]    cfg_index,
  input  wire logic [WEIGHT_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]          state;
  logic [TCNT_W-1:0]   target_count;
  logic [WEIGHT_W-1:0] change_threshold;
  logic [CNT_W-1:0]    occ;

  logic [IDX_W-1:0]    idx_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [SLOT_W-1:0]   chk_pos;
  logic [SLOT_W-1:0]   sh_pos;
  ord_entry_t          head_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [STATUS_W-1:0] status_r;
  logic                ev_valid_r;
  logic [IDX_W-1:0]    ev_index_r;

  logic [WEIGHT_W-1:0] wt_mem [NUM_TARGETS];
  logic                wt_valid [NUM_TARGETS];
  logic [WEIGHT_W-1:0] wt_rdata;
  logic                wt_rvalid;

  ord_entry_t          ord_mem [MAX_SLOTS];
  ord_entry_t          ord_rdata;
  logic [SLOT_W-1:0]   ord_raddr;
  logic                ord_we;
  ord_entry_t          ord_wdata;

  logic [SLOT_W-1:0]   out_slot;
  logic [WEIGHT_W-1:0] out_weight;
  logic                out_ev_valid;
  logic [IDX_W-1:0]    out_ev_index;

  logic [IDX_W-1:0]    s_idx;
  logic [RAW_W-1:0]    s_weight;
  logic [WEIGHT_W-1:0] s_clamped;
  logic                s_oor;
  logic                in_acc;

  logic [SLOT_W-1:0]   occ_last;
  logic                match;
  logic                scan_end;
  ord_entry_t          head_sel;
  logic [WEIGHT_W-1:0] old_w;
  logic [WEIGHT_W-1:0] diff;
  logic                too_small;
  logic                out_load;
  logic                ignored;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  assign s_idx    = s_tdata[IDX_W-1:0];
  assign s_weight = s_tdata[IDX_W +: RAW_W];

  // clamp to 0..1.0
  always_comb begin
    if (s_weight[RAW_W-1]) begin
      s_clamped = '0;
    end else if (s_weight[RAW_W-2:0] > {1'b0, W_ONE}) begin
      s_clamped = W_ONE;
    end else begin
      s_clamped = s_weight[WEIGHT_W-1:0];
    end
  end

  assign s_oor = ({1'b0, s_idx} >= target_count) || ({1'b0, s_idx} >= TARGETS_LIMIT);

  assign occ_last  = SLOT_W'(occ - 1'b1);
  assign match     = (occ != '0) && (ord_rdata.target == idx_r);
  assign scan_end  = (occ == '0) || match || (chk_pos == occ_last);
  assign head_sel  = (chk_pos == '0) ? ord_rdata : head_r;
  assign old_w     = wt_rvalid ? wt_rdata : '0;
  assign diff      = (old_w > w_r) ? (old_w - w_r) : (w_r - old_w);
  assign too_small = diff < change_threshold;
  assign out_load  = (state == S_OUT) && (!m_tvalid || m_tready);
  assign ignored   = (status_r == ST_RANGE) || (status_r == ST_SMALL);

  // recency memory addressing
  always_comb begin
    ord_raddr = '0;
    case (state)
      S_SCAN:  ord_raddr = SLOT_W'(chk_pos + 1'b1);
      S_PREP:  ord_raddr = SLOT_W'(sh_pos + 1'b1);
      S_SHIFT: ord_raddr = SLOT_W'(sh_pos + 2'd2);
      default: ord_raddr = '0;
    endcase
  end

  assign ord_we = (state == S_SHIFT);

  always_comb begin
    if (sh_pos == occ_last) begin
      ord_wdata.target = idx_r;
      ord_wdata.slot   = slot_r;
    end else begin
      ord_wdata = ord_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[sh_pos] <= ord_wdata;
    end
    ord_rdata <= ord_mem[ord_raddr];
  end

  // weight memory, written once per applied update (not for ignored items), read at acceptance
  always_ff @(posedge clk) begin
    if (state == S_SHIFT && sh_pos == occ_last) begin
      wt_mem[idx_r] <= w_r;
    end
    if (in_acc) begin
      wt_rdata <= wt_mem[s_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TARGETS; i++) begin
        wt_valid[i] <= 1'b0;
      end
    end else if (state == S_SHIFT && sh_pos == occ_last) begin
      wt_valid[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wt_rvalid <= wt_valid[s_idx];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      target_count     <= TARGET_COUNT_RST;
      change_threshold <= CHANGE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_COUNT:     target_count     <= cfg_data[TCNT_W-1:0];
        REG_CHANGE_THRESHOLD: change_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= s_oor ? S_OUT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            if (match && too_small) begin
              state <= S_OUT;
            end else begin
              state <= S_PREP;
              if (!match && occ < SLOTS_FULL) begin
                occ <= CNT_W'(occ + 1'b1);
              end
            end
          end
        end
        S_PREP: state <= S_SHIFT;
        S_SHIFT: begin
          if (sh_pos == occ_last) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          idx_r      <= s_idx;
          w_r        <= s_clamped;
          chk_pos    <= '0;
          slot_r     <= '0;
          ev_valid_r <= 1'b0;
          ev_index_r <= '0;
          status_r   <= s_oor ? ST_RANGE : ST_UPDATE;
        end
      end
      S_SCAN: begin
        if (chk_pos == '0) begin
          head_r <= ord_rdata;
        end
        if (scan_end) begin
          if (match) begin
            if (too_small) begin
              status_r <= ST_SMALL;
            end else begin
              status_r <= ST_UPDATE;
              slot_r   <= ord_rdata.slot;
              sh_pos   <= chk_pos;
            end
          end else if (occ < SLOTS_FULL) begin
            status_r <= ST_NEW;
            slot_r   <= occ[SLOT_W-1:0];
            sh_pos   <= occ[SLOT_W-1:0];
          end else begin
            status_r   <= ST_NEW;
            slot_r     <= head_sel.slot;
            ev_valid_r <= 1'b1;
            ev_index_r <= head_sel.target;
            sh_pos     <= '0;
          end
        end else begin
          chk_pos <= SLOT_W'(chk_pos + 1'b1);
        end
      end
      S_SHIFT: begin
        if (sh_pos != occ_last) begin
          sh_pos <= SLOT_W'(sh_pos + 1'b1);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser      <= status_r;
      out_slot     <= slot_r;
      out_weight   <= ignored ? '0 : w_r;
      out_ev_valid <= ev_valid_r;
      out_ev_index <= ev_index_r;
    end
  end

  assign m_tdata = {3'b000, out_ev_index, out_ev_valid, out_weight, out_slot};

endmodule

`default_nettype wire

// File: design/lswa_checker.sv
`default_nettype none
`include "lru_slot_weight_allocator_defines.svh"

module lswa_checker
  import lswa_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [31:0]         m_tdata,   // slot, applied_weight, evicted_valid,
                                             // evicted_index
  input wire logic [STATUS_W-1:0] m_tuser    // status
);

  `LSWA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  `LSWA_ASSERT_NOW(a_ignored_zero, clk, rst,
    m_tvalid && (m_tuser == ST_RANGE || m_tuser == ST_SMALL), m_tdata == '0)

  `LSWA_ASSERT_NOW(a_evict_new_only, clk, rst,
    m_tvalid && m_tuser == ST_UPDATE, !m_tdata[OUT_EV_VALID_BIT])

  `LSWA_ASSERT_NOW(a_weight_range, clk, rst,
    m_tvalid, m_tdata[OUT_WEIGHT_LSB +: WEIGHT_W] <= W_ONE)

  `LSWA_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind lru_slot_weight_allocator lswa_checker u_lswa_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lswa_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS      = 30;

  localparam logic [REG_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [REG_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [RAW_W-1:0] RAW_EDGES [6] = '{
    19'h00000, 19'h10000, 19'h10001, 19'h3FFFF, 19'h40000, 19'h7FFFF
  };

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic                ev_valid;
    logic [IDX_W-1:0]    ev_index;
  } alloc_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [REG_W-1:0]    sel;
    logic [WEIGHT_W-1:0] value;
    logic [IDX_W-1:0]    idx;
    logic [RAW_W-1:0]    raw;
    logic                typed;
    alloc_result_t       want;
  } dir_row_t;

  localparam alloc_result_t NO_RESULT = '0;

  // directed rows: typed expectations only after reset, at extremes and for error codes
  localparam dir_row_t DIR_ROWS [27] = '{
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd0, 19'h7FFFF, 1'b1,
      '{ST_NEW, 3'd0, 17'd0, 1'b0, 8'd0}},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd255, 19'h3FFFF, 1'b1,
      '{ST_NEW, 3'd1, W_ONE, 1'b0, 8'd0}},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd0, 19'h40000, 1'b1,
      '{ST_SMALL, 3'd0, 17'd0, 1'b0, 8'd0}},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd0, 19'd65, 1'b1,
      '{ST_SMALL, 3'd0, 17'd0, 1'b0, 8'd0}},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd0, 19'd66, 1'b1,
      '{ST_UPDATE, 3'd0, 17'd66, 1'b0, 8'd0}},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd1, 19'h10000, 1'b1,
      '{ST_NEW, 3'd2, W_ONE, 1'b0, 8'd0}},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd2, 19'h10001, 1'b1,
      '{ST_NEW, 3'd3, W_ONE, 1'b0, 8'd0}},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd3, 19'd1000, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd4, 19'd2000, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd5, 19'd3000, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd6, 19'd4000, 1'b0, NO_RESULT},
    // all slots full: least recently used target goes
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd7, 19'd5000, 1'b0, NO_RESULT},
    // evicted target returns while inactive
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd255, 19'h10000, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd3, 19'd1070, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_TARGET_COUNT, 17'd0, 8'd0, 19'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd0, 19'd100, 1'b1,
      '{ST_RANGE, 3'd0, 17'd0, 1'b0, 8'd0}},
    '{ROW_CFG, REG_TARGET_COUNT, 17'd5, 8'd0, 19'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd5, 19'd100, 1'b1,
      '{ST_RANGE, 3'd0, 17'd0, 1'b0, 8'd0}},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd4, 19'd2000, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_CHANGE_THRESHOLD, 17'd0, 8'd0, 19'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd4, 19'd2000, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_CHANGE_THRESHOLD, 17'h10000, 8'd0, 19'd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_TARGET_COUNT, 17'd0, 8'd4, 19'h3FFFF, 1'b0, NO_RESULT},
    // unknown register indexes are ignored
    '{ROW_CFG, REG_SPARE_2, 17'h1FFFF, 8'd0, 19'd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_SPARE_3, 17'h00000, 8'd0, 19'd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_TARGET_COUNT, 17'd256, 8'd0, 19'd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_CHANGE_THRESHOLD, 17'd66, 8'd0, 19'd0, 1'b0, NO_RESULT}
  };

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [31:0]         s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [31:0]         m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [REG_W-1:0]    cfg_index;
  logic [WEIGHT_W-1:0] cfg_data;

  // predictor state
  logic [IDX_W-1:0]    rec_target [MAX_SLOTS];
  logic [SLOT_W-1:0]   rec_slot [MAX_SLOTS];
  int unsigned         used_slots;
  logic [WEIGHT_W-1:0] weight_mem [NUM_TARGETS];
  bit                  active_mem [NUM_TARGETS];
  logic [TCNT_W-1:0]   tcount;
  logic [WEIGHT_W-1:0] thr;

  alloc_result_t pending_results [$];
  int            mismatch_count;
  int            result_count;
  int            sent_count;
  int            cfg_writes;
  int            status_seen [4];
  int            eviction_count;
  int            cycle_count;
  bit            quiet;
  bit            long_hold;

  lru_slot_weight_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_results.size());
    $display("lru_slot_weight_allocator test failed");
    $finish;
  end

  function automatic alloc_result_t predict_alloc(logic [IDX_W-1:0] idx,
                                                  logic [RAW_W-1:0] raw);
    alloc_result_t     r;
    logic [WEIGHT_W-1:0] w;
    int unsigned       diff;
    int unsigned       pos;
    int unsigned       k;
    bit                hit;
    logic [SLOT_W-1:0] s;
    r = '0;
    if (raw[RAW_W-1]) w = '0;
    else if (raw > RAW_W'(W_ONE)) w = W_ONE;
    else w = raw[WEIGHT_W-1:0];
    if (TCNT_W'(idx) >= tcount) begin
      r.status = ST_RANGE;
      return r;
    end
    diff = (weight_mem[idx] > w) ? weight_mem[idx] - w : w - weight_mem[idx];
    if (active_mem[idx] && diff < thr) begin
      r.status = ST_SMALL;
      return r;
    end
    hit = 1'b0;
    pos = 0;
    for (k = 0; k < used_slots; k++) begin
      if (!hit && rec_target[k] == idx) begin
        hit = 1'b1;
        pos = k;
      end
    end
    if (hit) begin
      s = rec_slot[pos];
      for (k = pos; k + 1 < used_slots; k++) begin
        rec_target[k] = rec_target[k+1];
        rec_slot[k] = rec_slot[k+1];
      end
      rec_target[used_slots-1] = idx;
      rec_slot[used_slots-1] = s;
      r.status = ST_UPDATE;
    end else if (used_slots < MAX_SLOTS) begin
      s = SLOT_W'(used_slots);
      rec_target[used_slots] = idx;
      rec_slot[used_slots] = s;
      used_slots++;
      r.status = ST_NEW;
    end else begin
      s = rec_slot[0];
      r.ev_valid = 1'b1;
      r.ev_index = rec_target[0];
      active_mem[rec_target[0]] = 1'b0;
      for (k = 0; k + 1 < MAX_SLOTS; k++) begin
        rec_target[k] = rec_target[k+1];
        rec_slot[k] = rec_slot[k+1];
      end
      rec_target[MAX_SLOTS-1] = idx;
      rec_slot[MAX_SLOTS-1] = s;
      r.status = ST_NEW;
    end
    weight_mem[idx] = w;
    active_mem[idx] = 1'b1;
    r.slot = s;
    r.weight = w;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what,
               got, want);
  endtask

  task automatic send_update(logic [IDX_W-1:0] idx, logic [RAW_W-1:0] raw, bit typed,
                             alloc_result_t typed_want);
    alloc_result_t want;
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, raw, idx};
    do @(posedge clk); while (!s_tready);
    want = predict_alloc(idx, raw);
    if (typed) want = typed_want;
    pending_results.insert(pending_results.size(), want);
    sent_count++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_W-1:0] sel, logic [WEIGHT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (sel == REG_TARGET_COUNT) tcount = value[TCNT_W-1:0];
    else if (sel == REG_CHANGE_THRESHOLD) thr = value;
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int n_items, logic [TCNT_W-1:0] tc, logic [WEIGHT_W-1:0] th,
                           int hold_at);
    int               base;
    int               span;
    int               delta;
    logic [IDX_W-1:0] idx;
    logic [RAW_W-1:0] raw;
    drain_results();
    write_reg(REG_TARGET_COUNT, WEIGHT_W'(tc));
    write_reg(REG_CHANGE_THRESHOLD, th);
    base = (int'(tc) > 12) ? int'($urandom_range(0, int'(tc) - 12)) : 0;
    for (int n = 0; n < n_items; n++) begin
      if (n == hold_at) long_hold = 1'b1;
      // mostly a small working set, so hits and evictions keep coming
      if ($urandom_range(0, 9) < 2) idx = IDX_W'($urandom_range(0, 255));
      else idx = IDX_W'(base + int'($urandom_range(0, 11)));
      case ($urandom_range(0, 7))
        0: raw = RAW_W'($urandom);
        1: raw = RAW_EDGES[$urandom_range(0, 5)];
        2, 3, 4: begin
          // close to the stored weight, around the threshold
          span = int'(thr) + 3;
          delta = int'($urandom_range(0, 2 * span)) - span;
          raw = RAW_W'(int'(weight_mem[idx]) + delta);
        end
        default: raw = RAW_W'($urandom_range(0, 65536));
      endcase
      send_update(idx, raw, 1'b0, NO_RESULT);
    end
  endtask

  // result side: random ready bursts, one long hold on request
  initial begin
    m_tready = 1'b0;
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.slot = m_tdata[OUT_SLOT_LSB +: SLOT_W];
      got.weight = m_tdata[OUT_WEIGHT_LSB +: WEIGHT_W];
      got.ev_valid = m_tdata[OUT_EV_VALID_BIT];
      got.ev_index = m_tdata[OUT_EV_INDEX_LSB +: IDX_W];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", got.status, 0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
        if (got.weight != want.weight) report_mismatch("weight", got.weight, want.weight);
        if (got.ev_valid != want.ev_valid)
          report_mismatch("evicted_valid", got.ev_valid, want.ev_valid);
        if (got.ev_index != want.ev_index)
          report_mismatch("evicted_index", got.ev_index, want.ev_index);
        status_seen[want.status]++;
        if (want.ev_valid) eviction_count++;
      end
      result_count++;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TARGET_COUNT;
    cfg_data = '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    result_count = 0;
    sent_count = 0;
    cfg_writes = 0;
    eviction_count = 0;
    status_seen = '{0, 0, 0, 0};
    used_slots = 0;
    tcount = TARGET_COUNT_RST;
    thr = CHANGE_THRESHOLD_RST;
    for (int t = 0; t < NUM_TARGETS; t++) begin
      weight_mem[t] = '0;
      active_mem[t] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        drain_results();
        write_reg(DIR_ROWS[r].sel, DIR_ROWS[r].value);
      end else begin
        send_update(DIR_ROWS[r].idx, DIR_ROWS[r].raw, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end
    end

    run_phase(210, 9'd256, 17'd66, -1);
    run_phase(210, 9'd256, 17'd0, 100);
    run_phase(210, 9'd256, 17'h10000, -1);
    run_phase(210, TCNT_W'($urandom_range(1, 256)), WEIGHT_W'($urandom_range(0, 3000)), -1);
    run_phase(200, 9'd12, 17'd300, -1);
    run_phase(40, 9'd0, WEIGHT_W'($urandom_range(0, 65536)), -1);
    quiet = 1'b1;
    run_phase(210, 9'd256, WEIGHT_W'($urandom_range(0, 500)), -1);

    drain_results();
    repeat (30) @(posedge clk);

    $display("%0d updates over %0d register writes, %0d results checked", sent_count,
             cfg_writes, result_count);
    $display("existing %0d, new slot %0d (%0d evictions), out of range %0d, too small %0d",
             status_seen[ST_UPDATE], status_seen[ST_NEW], eviction_count,
             status_seen[ST_RANGE], status_seen[ST_SMALL]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("lru_slot_weight_allocator test passed");
    end else begin
      $display("lru_slot_weight_allocator test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/lswa_pkg.sv
design/lru_slot_weight_allocator.sv
design/lswa_checker.sv
tb/testbench.sv
